@@ src/bpa_pkg.sv @@
// Shared constants, request codes and the free-bit search for the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    // Map words hold 64 page bits; summary words hold one full flag per map word.
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    localparam int REQ_W  = 2;
    localparam int IDX_W  = 12;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 21;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_USED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'd1;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0010_0000;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 21'h00_1000;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [WORD_SHIFT-1:0] bitpos_t;

    // Position of the lowest clear bit; zero when every bit is set.
    function automatic bitpos_t lowest_zero(input word_t w);
        bitpos_t pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = bitpos_t'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ src/bpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/bpa_addr.sv @@
// Two-stage page address unit: index times page size, then plus base.
`timescale 1ns / 1ps

module bpa_addr #(
    parameter int PW = 12
) (
    input  logic                          aclk,
    input  logic [PW-1:0]                 page,
    input  logic [bpa_pkg::SIZE_W-1:0]    page_size,
    input  logic [bpa_pkg::ADDR_W-1:0]    base_address,
    output logic [bpa_pkg::ADDR_W-1:0]    address
);

    logic [bpa_pkg::ADDR_W-1:0] prod_reg;
    logic [bpa_pkg::ADDR_W-1:0] addr_reg;

    // The product only matters modulo 2^32, so both operands are widened to 32 bits
    // and the upper bits of the product are dropped.
    always_ff @(posedge aclk) begin
        prod_reg <= bpa_pkg::ADDR_W'(page) * bpa_pkg::ADDR_W'(page_size);
        addr_reg <= prod_reg + base_address;
    end

    assign address = addr_reg;

endmodule

@@ src/bitmap_page_allocator.sv @@
// Top level of the bitmap page allocator: request sequencer, usage map and summary memories.
`timescale 1ns / 1ps

// The allocator keeps one usage bit per page in a map memory of 64-bit words and
// one "word full" flag per map word in a summary memory; a small flip-flop vector
// marks which summary words still point at a word with a free page. After reset
// the block runs a clearing pass over every map word that marks every page free
// and the padding bits past the last page used; no beat is accepted on s_ during
// that pass, while configuration writes are taken at any time. The block handles
// one request at a time. From the accepting edge to the result beat being loaded
// on m_, a mark-free or mark-used request reads map and summary, writes both back
// and loads the result; an allocate does a summary read, a map read, the write
// back, two stages of the multiply-add address unit and the result load; an
// allocate on a full map, a mark beyond the last page or an undefined request
// type goes straight to the result load. The next request is accepted as soon
// as the sequencer is idle, even while the previous result still waits on m_.
// Configuration writes are meant for an idle block.
module bitmap_page_allocator #(
    parameter int PAGE_COUNT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Request channel. s_tdata: [1:0] req_type, [13:2] page_index, [15:14] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,

    // Result channel. m_tdata: [0] status, [12:1] granted_index,
    // [44:13] granted_address, [47:45] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,

    // Configuration write channel: index 0 base_address, index 1 page_size.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]     cfg_data
);

    localparam int WB         = bpa_pkg::WORD_BITS;
    localparam int WSH        = bpa_pkg::WORD_SHIFT;
    localparam int PW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int LEAF_WORDS = (PAGE_COUNT + WB - 1) / WB;
    localparam int LEAF_AW    = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
    localparam int SUM_WORDS  = (LEAF_WORDS + WB - 1) / WB;
    localparam int SUM_AW     = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;

    // Bits past the last page (or past the last map word) start out marked used,
    // so the search never lands on them.
    localparam bpa_pkg::word_t LEAF_PAD = (PAGE_COUNT % WB == 0) ? '0 :
        ~((bpa_pkg::word_t'(1) << (PAGE_COUNT % WB)) - bpa_pkg::word_t'(1));
    localparam bpa_pkg::word_t SUM_PAD = (LEAF_WORDS % WB == 0) ? '0 :
        ~((bpa_pkg::word_t'(1) << (LEAF_WORDS % WB)) - bpa_pkg::word_t'(1));

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_MODIFY,
        S_ADDR1,
        S_ADDR2,
        S_RESP
    } state_t;

    state_t                         state_reg;
    logic [LEAF_AW-1:0]             clr_cnt_reg;
    logic                           alloc_reg;
    logic                           set_reg;
    logic                           grant_reg;
    logic                           full_reg;
    logic [SUM_AW-1:0]              sw_reg;
    logic [LEAF_AW-1:0]             leaf_reg;
    bpa_pkg::bitpos_t               bit_reg;
    logic [PW-1:0]                  page_reg;
    logic [SUM_WORDS-1:0]           top_reg;
    logic [bpa_pkg::ADDR_W-1:0]     base_reg;
    logic [bpa_pkg::SIZE_W-1:0]     size_reg;

    logic                           m_tvalid_reg;
    logic                           out_status_reg;
    logic [bpa_pkg::IDX_W-1:0]      out_index_reg;
    logic [bpa_pkg::ADDR_W-1:0]     out_addr_reg;

    // Request decode.
    logic [bpa_pkg::REQ_W-1:0]      in_req;
    logic [bpa_pkg::IDX_W-1:0]      in_idx;
    logic                           in_accept;
    logic                           in_alloc;
    logic                           in_mark;
    logic [LEAF_AW-1:0]             idx_leaf;
    logic [SUM_AW-1:0]              idx_sum;
    logic                           top_any;
    logic [SUM_AW-1:0]              top_pick;

    // Search and update.
    bpa_pkg::word_t                 leaf_rdata;
    bpa_pkg::word_t                 sum_rdata;
    bpa_pkg::bitpos_t               look_bit;
    logic [LEAF_AW-1:0]             look_leaf;
    bpa_pkg::bitpos_t               sel_bit;
    bpa_pkg::bitpos_t               leaf_pos;
    bpa_pkg::word_t                 leaf_next;
    bpa_pkg::word_t                 sum_next;
    logic                           leaf_full;
    logic [PW-1:0]                  page_next;
    logic                           clr_last;

    // Memory ports.
    logic                           leaf_we;
    logic [LEAF_AW-1:0]             leaf_waddr;
    bpa_pkg::word_t                 leaf_wdata;
    logic                           leaf_re;
    logic [LEAF_AW-1:0]             leaf_raddr;
    logic                           sum_we;
    logic [SUM_AW-1:0]              sum_waddr;
    bpa_pkg::word_t                 sum_wdata;
    logic                           sum_re;
    logic [SUM_AW-1:0]              sum_raddr;

    logic [bpa_pkg::ADDR_W-1:0]     page_addr;

    assign in_req    = s_tdata[1:0];
    assign in_idx    = s_tdata[13:2];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_alloc  = (in_req == bpa_pkg::REQ_ALLOC);
    // Marks beyond the last page are dropped and only answered.
    assign in_mark   = ((in_req == bpa_pkg::REQ_FREE) || (in_req == bpa_pkg::REQ_USED)) &&
                       (32'(in_idx) < 32'(PAGE_COUNT));
    assign idx_leaf  = LEAF_AW'(in_idx >> WSH);
    assign idx_sum   = SUM_AW'(in_idx >> (2 * WSH));
    assign top_any   = |top_reg;

    // Lowest summary word that still covers a map word with a free page.
    always_comb begin
        top_pick = '0;
        for (int i = SUM_WORDS - 1; i >= 0; i--) begin
            if (top_reg[i]) begin
                top_pick = SUM_AW'(i);
            end
        end
    end

    assign look_bit  = bpa_pkg::lowest_zero(sum_rdata);
    assign look_leaf = LEAF_AW'({sw_reg, look_bit});

    // Read-modify-write of one map word and its summary word.
    assign sel_bit   = alloc_reg ? bpa_pkg::lowest_zero(leaf_rdata) : bit_reg;
    assign leaf_next = set_reg ? (leaf_rdata | (bpa_pkg::word_t'(1) << sel_bit))
                               : (leaf_rdata & ~(bpa_pkg::word_t'(1) << sel_bit));
    assign leaf_full = &leaf_next;
    assign leaf_pos  = bpa_pkg::bitpos_t'(leaf_reg);
    assign sum_next  = leaf_full ? (sum_rdata | (bpa_pkg::word_t'(1) << leaf_pos))
                                 : (sum_rdata & ~(bpa_pkg::word_t'(1) << leaf_pos));
    assign page_next = PW'({leaf_reg, sel_bit});
    assign clr_last  = (clr_cnt_reg == LEAF_AW'(LEAF_WORDS - 1));

    always_comb begin
        leaf_we    = 1'b0;
        leaf_waddr = leaf_reg;
        leaf_wdata = leaf_next;
        sum_we     = 1'b0;
        sum_waddr  = sw_reg;
        sum_wdata  = sum_next;
        case (state_reg)
            S_CLEAR: begin
                leaf_we    = 1'b1;
                leaf_waddr = clr_cnt_reg;
                leaf_wdata = clr_last ? LEAF_PAD : '0;
                sum_we     = ((LEAF_AW + 1)'(clr_cnt_reg) < (LEAF_AW + 1)'(SUM_WORDS));
                sum_waddr  = SUM_AW'(clr_cnt_reg);
                sum_wdata  = (clr_cnt_reg == LEAF_AW'(SUM_WORDS - 1)) ? SUM_PAD : '0;
            end
            S_MODIFY: begin
                leaf_we = 1'b1;
                sum_we  = 1'b1;
            end
            default: begin
                leaf_we = 1'b0;
                sum_we  = 1'b0;
            end
        endcase
    end

    assign sum_re     = in_accept && ((in_alloc && top_any) || in_mark);
    assign sum_raddr  = in_alloc ? top_pick : idx_sum;
    assign leaf_re    = (in_accept && in_mark) || (state_reg == S_LOOK);
    assign leaf_raddr = (state_reg == S_LOOK) ? look_leaf : idx_leaf;

    bpa_ram #(
        .WIDTH (WB),
        .DEPTH (LEAF_WORDS)
    ) u_leaf_ram (
        .aclk    (aclk),
        .wr_en   (leaf_we),
        .wr_addr (leaf_waddr),
        .wr_data (leaf_wdata),
        .rd_en   (leaf_re),
        .rd_addr (leaf_raddr),
        .rd_data (leaf_rdata)
    );

    bpa_ram #(
        .WIDTH (WB),
        .DEPTH (SUM_WORDS)
    ) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (sum_we),
        .wr_addr (sum_waddr),
        .wr_data (sum_wdata),
        .rd_en   (sum_re),
        .rd_addr (sum_raddr),
        .rd_data (sum_rdata)
    );

    bpa_addr #(
        .PW (PW)
    ) u_addr (
        .aclk         (aclk),
        .page         (page_reg),
        .page_size    (size_reg),
        .base_address (base_reg),
        .address      (page_addr)
    );

    // Configuration registers accept a write in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= bpa_pkg::BASE_RESET;
            size_reg <= bpa_pkg::SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bpa_pkg::CFG_BASE: base_reg <= cfg_data;
                bpa_pkg::CFG_SIZE: size_reg <= cfg_data[bpa_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Request sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            top_reg      <= '1;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In the result state the load below decides the valid flag itself.
            if (m_tvalid_reg && m_tready && (state_reg != S_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + LEAF_AW'(1);
                    if (clr_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        alloc_reg <= in_alloc;
                        set_reg   <= in_alloc || (in_req == bpa_pkg::REQ_USED);
                        bit_reg   <= in_idx[WSH-1:0];
                        leaf_reg  <= idx_leaf;
                        sw_reg    <= in_alloc ? top_pick : idx_sum;
                        grant_reg <= 1'b0;
                        full_reg  <= in_alloc && !top_any;
                        if (in_alloc && top_any) begin
                            state_reg <= S_LOOK;
                        end else if (in_mark) begin
                            state_reg <= S_MODIFY;
                        end else begin
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_LOOK: begin
                    leaf_reg  <= look_leaf;
                    state_reg <= S_MODIFY;
                end
                S_MODIFY: begin
                    page_reg        <= page_next;
                    top_reg[sw_reg] <= ~(&sum_next);
                    grant_reg       <= alloc_reg;
                    state_reg       <= alloc_reg ? S_ADDR1 : S_RESP;
                end
                S_ADDR1: begin
                    state_reg <= S_ADDR2;
                end
                S_ADDR2: begin
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= full_reg;
                        out_index_reg  <= grant_reg ? bpa_pkg::IDX_W'(page_reg) : '0;
                        out_addr_reg   <= grant_reg ? page_addr : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_addr_reg, out_index_reg, out_status_reg};

    // A full status is only ever answered when no summary word has a free map word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && full_reg) |-> (top_reg == '0))
        else $error("full status reported while the summary shows a free page");

    // The summary sent the search to this map word, so it must hold a free bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MODIFY && alloc_reg) |-> !(&leaf_rdata))
        else $error("allocate reached a map word with no free page");

    // A granted page always lies inside the managed range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && grant_reg) |-> (32'(page_reg) < 32'(PAGE_COUNT)))
        else $error("granted page index beyond the page count");

    // The clearing pass hands over to idle exactly once it has covered the map.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR && clr_last) |=> (state_reg == S_IDLE && top_reg == '1))
        else $error("clearing pass ended in a wrong state");

endmodule

@@ tb/sv/bitmap_page_allocator_test.sv @@
// Self-checking testbench for the bitmap page allocator: directed, fill and random request traffic.
`timescale 1ns / 1ps

// The testbench keeps its own copy of the page usage bits and the two configuration
// registers. Each request beat accepted on s_ is applied to that copy, and the grant it
// should produce is queued. Every result beat accepted on m_ is compared field by field
// with the oldest queued grant. Both sides insert a random gap, possibly none, per beat.
// Some stretches run with no gaps, and one stretch holds the result side off long enough
// that the block stalls its request side.
module bitmap_page_allocator_test;

    localparam int PAGES       = 4096;
    localparam int MAX_GAP     = 17;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 1_000_000;

    // The package names three request codes; the fourth encoding is undefined and must
    // be answered with an all-zero grant.
    localparam logic [bpa_pkg::REQ_W-1:0] REQ_UNDEFINED = 2'd3;

    typedef struct packed {
        logic                       status;
        logic [bpa_pkg::IDX_W-1:0]  index;
        logic [bpa_pkg::ADDR_W-1:0] address;
    } grant_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    // s_tdata: [1:0] req_type, [13:2] page_index, [15:14] zero.
    logic [15:0]                   s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    // m_tdata: [0] status, [12:1] granted_index, [44:13] granted_address, [47:45] zero.
    logic [47:0]                   m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index = bpa_pkg::CFG_BASE;
    logic [bpa_pkg::ADDR_W-1:0]    cfg_data  = '0;

    // Predicted state of the block.
    bit   [PAGES-1:0]              page_busy;
    logic [bpa_pkg::ADDR_W-1:0]    base_setting = bpa_pkg::BASE_RESET;
    logic [bpa_pkg::SIZE_W-1:0]    size_setting = bpa_pkg::SIZE_RESET;
    grant_t                        pending_grants[$];

    // Controls shared by the stimulus and the result-side driver.
    bit                            idle_off;
    bit                            request_held;
    int                            ready_hold_cycles;
    int                            error_count;
    int                            cycle_count;

    bitmap_page_allocator #(
        .PAGE_COUNT(PAGES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The run is ended here if it hangs; a correct run stays far below this limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Applies one request to the predicted usage bits and returns the grant it yields.
    // An allocate takes the lowest free page. Its address is index * size + base, and
    // it wraps at 32 bits. With no free page the map stays as it is and status is set.
    function automatic grant_t grant_for_request(input logic [bpa_pkg::REQ_W-1:0] req,
                                                 input logic [bpa_pkg::IDX_W-1:0] page);
        grant_t g;
        int     found;
        g = '0;
        found = -1;
        case (req)
            bpa_pkg::REQ_ALLOC: begin
                for (int p = 0; p < PAGES; p++) begin
                    if (!page_busy[p]) begin
                        found = p;
                        break;
                    end
                end
                if (found < 0) begin
                    g.status = 1'b1;
                end else begin
                    page_busy[found] = 1'b1;
                    g.index   = found[bpa_pkg::IDX_W-1:0];
                    g.address = bpa_pkg::ADDR_W'(found) * bpa_pkg::ADDR_W'(size_setting)
                                + base_setting;
                end
            end
            bpa_pkg::REQ_FREE: begin
                page_busy[page] = 1'b0;
            end
            bpa_pkg::REQ_USED: begin
                page_busy[page] = 1'b1;
            end
            default: begin
            end
        endcase
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] want,
                                   input logic [47:0] got);
        $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                 cycle_count, what, want, got);
        error_count++;
    endtask

    // Offers one request beat after a random gap. If the gap is zero, s_tvalid stays
    // high from the previous beat and only the data changes. This avoids lowering and
    // raising it in the same step.
    task automatic send_request(input logic [bpa_pkg::REQ_W-1:0] req,
                                input logic [bpa_pkg::IDX_W-1:0] page);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            if (request_held) begin
                s_tvalid <= 1'b0;
                request_held = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, page, req};
        request_held = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_grants.push_back(grant_for_request(req, page));
    endtask

    // Lowers the request valid and waits until every predicted grant has been seen.
    // The block is then idle, so configuration writes are safe.
    task automatic drain_results();
        if (request_held) begin
            s_tvalid <= 1'b0;
            request_held = 1'b0;
        end
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes both registers in back-to-back beats. The page size register keeps only
    // its low 21 bits.
    task automatic set_config(input logic [bpa_pkg::ADDR_W-1:0] base,
                              input logic [31:0] size);
        cfg_valid <= 1'b1;
        cfg_index <= bpa_pkg::CFG_BASE;
        cfg_data  <= base;
        do @(posedge aclk); while (!cfg_ready);
        base_setting = base;
        cfg_index <= bpa_pkg::CFG_SIZE;
        cfg_data  <= size;
        do @(posedge aclk); while (!cfg_ready);
        size_setting = size[bpa_pkg::SIZE_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic check_grant(input logic [47:0] beat);
        grant_t want;
        if (pending_grants.size() == 0) begin
            report_mismatch("result beat with nothing outstanding", '0, beat);
            return;
        end
        want = pending_grants.pop_front();
        if (beat[0] !== want.status)
            report_mismatch("status", 48'(want.status), 48'(beat[0]));
        if (beat[12:1] !== want.index)
            report_mismatch("granted_index", 48'(want.index), 48'(beat[12:1]));
        if (beat[44:13] !== want.address)
            report_mismatch("granted_address", 48'(want.address), 48'(beat[44:13]));
        if (beat[47:45] !== 3'b000)
            report_mismatch("padding", '0, 48'(beat[47:45]));
    endtask

    // Result monitor. Both valid and ready are sampled at the clock edge, so every
    // accepted beat is seen exactly once.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_grant(m_tdata);
        end
    end

    // Result-side driver. Before each beat it waits a random number of cycles, or
    // none when idling is off. When a long hold-off is requested, it keeps m_tready
    // low for that many cycles first.
    initial begin : result_ready_driver
        int gap;
        int hold;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (ready_hold_cycles > 0) begin
                hold = ready_hold_cycles;
                ready_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Reset values of the registers, lowest-page order, reuse of a freed page, marking
    // a page that is already used, the highest page index, an undefined request type,
    // and an allocate whose page field carries bits that must be ignored.
    task automatic test_reset_defaults();
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        send_request(bpa_pkg::REQ_FREE, 12'h001);
        send_request(bpa_pkg::REQ_ALLOC, 12'hAAA);
        send_request(bpa_pkg::REQ_USED, 12'h003);
        send_request(bpa_pkg::REQ_ALLOC, 12'h555);
        send_request(REQ_UNDEFINED, 12'hFFF);
        send_request(bpa_pkg::REQ_USED, 12'h000);
        send_request(bpa_pkg::REQ_FREE, 12'hFFF);
        send_request(bpa_pkg::REQ_USED, 12'hFFF);
        send_request(bpa_pkg::REQ_FREE, 12'hFFF);
        send_request(REQ_UNDEFINED, 12'h000);
        drain_results();
    endtask

    // Register extremes: a full base with a page size of 2^20, which wraps. Also the
    // smallest page size with a zero base, a zero page size, and a page size written
    // with every bit set, of which only the low 21 bits count.
    task automatic test_config_extremes();
        set_config(32'hFFFF_FFFF, 32'h0010_0000);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        drain_results();
        set_config(32'h0000_0000, 32'h0000_0001);
        send_request(bpa_pkg::REQ_ALLOC, 12'hFFF);
        drain_results();
        set_config(32'h1234_5678, 32'h0000_0000);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        drain_results();
        set_config(32'h8000_0000, 32'hFFFF_FFFF);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        drain_results();
    endtask

    // Allocates until the map is full and then some more, so the full status is
    // answered. Then pages are freed at the top, in the middle and low down and are
    // granted again in lowest-first order. This runs without idling on either side.
    task automatic test_full_map();
        set_config(32'hFFFF_F000, 32'h0000_1000);
        idle_off = 1'b1;
        repeat (PAGES + 2) send_request(bpa_pkg::REQ_ALLOC, bpa_pkg::IDX_W'($urandom));
        send_request(bpa_pkg::REQ_FREE, 12'hFFF);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        send_request(bpa_pkg::REQ_FREE, 12'h800);
        send_request(bpa_pkg::REQ_FREE, 12'h007);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        send_request(bpa_pkg::REQ_ALLOC, 12'h000);
        idle_off = 1'b0;
        drain_results();
    endtask

    // The result side holds off for a long stretch while requests keep coming. The
    // block holds one result, finishes the next request and then stops taking more.
    task automatic test_backpressure();
        set_config(32'h0040_0000, 32'h0000_2000);
        idle_off = 1'b1;
        ready_hold_cycles = 400;
        for (int n = 0; n < 24; n++) begin
            if (n % 2 == 0)
                send_request(bpa_pkg::REQ_FREE, bpa_pkg::IDX_W'($urandom));
            else
                send_request(bpa_pkg::REQ_ALLOC, bpa_pkg::IDX_W'($urandom));
        end
        idle_off = 1'b0;
        drain_results();
    endtask

    // One phase of random requests. The allocate share decides whether the map tends
    // to fill up or to empty out. Mark requests hit either the whole index range or
    // the low pages, where allocations land first.
    task automatic run_random_phase(input int beats, input int alloc_pct);
        int                        kind;
        logic [bpa_pkg::IDX_W-1:0] page;
        for (int n = 0; n < beats; n++) begin
            page = ($urandom_range(0, 2) == 0) ? bpa_pkg::IDX_W'($urandom_range(0, 255))
                                               : bpa_pkg::IDX_W'($urandom);
            if ($urandom_range(0, 99) < alloc_pct) begin
                send_request(bpa_pkg::REQ_ALLOC, page);
            end else begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                    send_request(REQ_UNDEFINED, page);
                else if (kind < 6)
                    send_request(bpa_pkg::REQ_USED, page);
                else
                    send_request(bpa_pkg::REQ_FREE, page);
            end
        end
        drain_results();
    endtask

    // Random traffic starts from the nearly full map and runs through several register
    // settings. One phase runs without idling.
    task automatic test_random_traffic();
        set_config($urandom, $urandom_range(1, 32'h0010_0000));
        run_random_phase(400, 30);
        set_config(32'h0000_0000, 32'h0010_0000);
        idle_off = 1'b1;
        run_random_phase(400, 60);
        idle_off = 1'b0;
        set_config(32'hFFFF_FFFF, 32'h0000_0001);
        run_random_phase(400, 45);
        set_config($urandom, 32'h0000_0000);
        run_random_phase(400, 70);
        set_config($urandom, $urandom);
        run_random_phase(400, 50);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_config_extremes();
        test_full_map();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
